@@ hw/rtl/eulr_pkg.sv @@
// ----------------------------------------------------------------------------
// Euler XYZ rotation package
// Widths, CORDIC constants and shared types for the vertex rotation core.
// ----------------------------------------------------------------------------
package eulr_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int TRIG_FRAC    = 24;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_FRAC  = 30;
  localparam int WIDE_W       = COORD_WIDTH + 2;
  localparam int TRIG_W       = TRIG_FRAC + 2;
  localparam int PROD_W       = WIDE_W + TRIG_W;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int ROT_LAT      = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic signed [TRIG_W-1:0]      trig_t;
  typedef logic signed [CORDIC_W-1:0]    cval_t;
  typedef logic [ANGLE_WIDTH-1:0]        angle_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } trig_pair_t;

  localparam cval_t CORDIC_START = 32'sd652032874;

  localparam cval_t ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

@@ hw/rtl/eulr_cordic.sv @@
// ----------------------------------------------------------------------------
// Euler XYZ rotation CORDIC
// Quadrant fold, one register stage per CORDIC step, then rounding of
// cosine and sine to the trig format.
// ----------------------------------------------------------------------------
module eulr_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  eulr_pkg::angle_t      angle_i,
  output logic                  valid_o,
  output eulr_pkg::trig_pair_t  trig_o
);

  localparam int Steps = eulr_pkg::CORDIC_STEPS;
  localparam int Shift = eulr_pkg::CORDIC_FRAC - eulr_pkg::TRIG_FRAC;
  localparam eulr_pkg::cval_t Half = eulr_pkg::cval_t'(1) <<< (Shift - 1);

  logic [eulr_pkg::CORDIC_W-1:0] turn_w;
  logic [eulr_pkg::CORDIC_W-1:0] bias_w;
  logic [1:0]                    quad_w;
  eulr_pkg::cval_t               rest_w;

  eulr_pkg::cval_t x_q [Steps+1];
  eulr_pkg::cval_t y_q [Steps+1];
  eulr_pkg::cval_t z_q [Steps+1];
  logic [1:0]      quad_q [Steps+1];
  logic [Steps:0]  vld_q;

  eulr_pkg::cval_t  xr_w;
  eulr_pkg::cval_t  yr_w;
  eulr_pkg::trig_t  co_w;
  eulr_pkg::trig_t  si_w;
  eulr_pkg::trig_pair_t trig_d;
  eulr_pkg::trig_pair_t trig_q;
  logic                 vout_q;

  always_comb begin
    turn_w = eulr_pkg::CORDIC_W'(angle_i) << (eulr_pkg::CORDIC_W - eulr_pkg::ANGLE_WIDTH);
    bias_w = turn_w + 32'h2000_0000;
    quad_w = bias_w[eulr_pkg::CORDIC_W-1 -: 2];
    rest_w = eulr_pkg::cval_t'(turn_w - {quad_w, 30'b0});
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= eulr_pkg::CORDIC_START;
    y_q[0]    <= '0;
    z_q[0]    <= rest_w;
    quad_q[0] <= quad_w;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - eulr_pkg::ATAN_TURN[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + eulr_pkg::ATAN_TURN[i];
      end
      quad_q[i+1] <= quad_q[i];
    end
  end

  always_comb begin
    xr_w = (x_q[Steps] + Half) >>> Shift;
    yr_w = (y_q[Steps] + Half) >>> Shift;
    co_w = eulr_pkg::trig_t'(xr_w);
    si_w = eulr_pkg::trig_t'(yr_w);
    case (quad_q[Steps])
      2'd0: begin
        trig_d.c = co_w;
        trig_d.s = si_w;
      end
      2'd1: begin
        trig_d.c = -si_w;
        trig_d.s = co_w;
      end
      2'd2: begin
        trig_d.c = -co_w;
        trig_d.s = -si_w;
      end
      default: begin
        trig_d.c = si_w;
        trig_d.s = -co_w;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[Steps-1:0], valid_i};
      vout_q <= vld_q[Steps];
    end
  end

  assign valid_o = vout_q;
  assign trig_o  = trig_q;

endmodule

@@ hw/rtl/eulr_rot.sv @@
// ----------------------------------------------------------------------------
// Euler XYZ rotation plane stage
// Rotates the pair (a, b) by one angle: products in the first stage,
// rounded sums in the second. A third coordinate rides along.
// ----------------------------------------------------------------------------
module eulr_rot (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  eulr_pkg::wide_t       a_i,
  input  eulr_pkg::wide_t       b_i,
  input  eulr_pkg::wide_t       pass_i,
  input  eulr_pkg::trig_pair_t  trig_i,
  output logic                  valid_o,
  output eulr_pkg::wide_t       p_o,
  output eulr_pkg::wide_t       r_o,
  output eulr_pkg::wide_t       pass_o
);

  localparam int Pw = eulr_pkg::PROD_W;
  localparam logic signed [Pw:0] Round = (Pw+1)'(1) <<< (eulr_pkg::TRIG_FRAC - 1);

  logic signed [Pw-1:0] ac_q, bs_q, as_q, bc_q;
  eulr_pkg::wide_t      pass1_q, pass2_q, p_q, r_q;
  logic signed [Pw:0]   psum_w, rsum_w;
  logic [1:0]           vld_q;

  always_ff @(posedge clk_i) begin
    ac_q    <= Pw'(a_i) * Pw'(trig_i.c);
    bs_q    <= Pw'(b_i) * Pw'(trig_i.s);
    as_q    <= Pw'(a_i) * Pw'(trig_i.s);
    bc_q    <= Pw'(b_i) * Pw'(trig_i.c);
    pass1_q <= pass_i;
  end

  always_comb begin
    psum_w = ((Pw+1)'(ac_q) - (Pw+1)'(bs_q) + Round) >>> eulr_pkg::TRIG_FRAC;
    rsum_w = ((Pw+1)'(as_q) + (Pw+1)'(bc_q) + Round) >>> eulr_pkg::TRIG_FRAC;
  end

  always_ff @(posedge clk_i) begin
    p_q     <= eulr_pkg::wide_t'(psum_w);
    r_q     <= eulr_pkg::wide_t'(rsum_w);
    pass2_q <= pass1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign p_o     = p_q;
  assign r_o     = r_q;
  assign pass_o  = pass2_q;

endmodule

@@ hw/rtl/euler_xyz_vertex_rotation_core.sv @@
// ----------------------------------------------------------------------------
// Euler XYZ vertex rotation core
// Rotates a vertex about X, then Y, then Z, and saturates the result.
//
// Input: raise start with a vertex and three binary angles; the item is
// taken at any edge where start is high and busy is low. busy stays low,
// so one item can be taken every cycle.
// Output: valid_o marks the rotated vertex for exactly one cycle; the
// receiver cannot stall and must take it then.
// Pipeline: the accepting edge feeds the pipelined 24-step CORDIC (fold,
// steps, rounding), then each of the three plane rotations (products,
// sums) and finally saturation, whose register drives valid_o.
// Throughput: one item per cycle.
// Reset clears all valid bits; items in flight are dropped and no result
// appears until a new item is taken.
// ----------------------------------------------------------------------------
module euler_xyz_vertex_rotation_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  eulr_pkg::coord_t  vertex_x_i,
  input  eulr_pkg::coord_t  vertex_y_i,
  input  eulr_pkg::coord_t  vertex_z_i,
  input  eulr_pkg::angle_t  angle_x_i,
  input  eulr_pkg::angle_t  angle_y_i,
  input  eulr_pkg::angle_t  angle_z_i,
  output logic              valid_o,
  output eulr_pkg::coord_t  rotated_x_o,
  output eulr_pkg::coord_t  rotated_y_o,
  output eulr_pkg::coord_t  rotated_z_o
);

  localparam int Lat = eulr_pkg::CORDIC_LAT;
  localparam int Rl  = eulr_pkg::ROT_LAT;
  localparam eulr_pkg::wide_t Hi =
    eulr_pkg::wide_t'({1'b0, {(eulr_pkg::COORD_WIDTH-1){1'b1}}});
  localparam eulr_pkg::wide_t Lo = -Hi - eulr_pkg::wide_t'(1);

  logic accept_w;

  eulr_pkg::wide_t vx_q [Lat];
  eulr_pkg::wide_t vy_q [Lat];
  eulr_pkg::wide_t vz_q [Lat];

  logic                 tx_vld_w;
  eulr_pkg::trig_pair_t tx_w, ty_w, tz_w;
  eulr_pkg::trig_pair_t ty_q [Rl];
  eulr_pkg::trig_pair_t tz_q [2*Rl];
  eulr_pkg::trig_pair_t ty_neg_w;

  logic            r1_vld_w, r2_vld_w, r3_vld_w;
  eulr_pkg::wide_t r1_y_w, r1_z_w, r1_x_w;
  eulr_pkg::wide_t r2_x_w, r2_z_w, r2_y_w;
  eulr_pkg::wide_t r3_x_w, r3_y_w, r3_z_w;

  eulr_pkg::coord_t ox_q, oy_q, oz_q;
  logic             ovld_q;

  function automatic eulr_pkg::coord_t sat(eulr_pkg::wide_t v);
    eulr_pkg::wide_t t;
    t = v;
    if (v > Hi) t = Hi;
    if (v < Lo) t = Lo;
    return eulr_pkg::coord_t'(t);
  endfunction

  assign busy     = 1'b0;
  assign accept_w = start & ~busy;

  always_ff @(posedge clk_i) begin
    vx_q[0] <= eulr_pkg::wide_t'(vertex_x_i);
    vy_q[0] <= eulr_pkg::wide_t'(vertex_y_i);
    vz_q[0] <= eulr_pkg::wide_t'(vertex_z_i);
    for (int k = 1; k < Lat; k++) begin
      vx_q[k] <= vx_q[k-1];
      vy_q[k] <= vy_q[k-1];
      vz_q[k] <= vz_q[k-1];
    end
  end

  eulr_cordic u_cordic_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_w),
    .angle_i (angle_x_i),
    .valid_o (tx_vld_w),
    .trig_o  (tx_w)
  );

  eulr_cordic u_cordic_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_w),
    .angle_i (angle_y_i),
    .valid_o (),
    .trig_o  (ty_w)
  );

  eulr_cordic u_cordic_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_w),
    .angle_i (angle_z_i),
    .valid_o (),
    .trig_o  (tz_w)
  );

  always_ff @(posedge clk_i) begin
    ty_q[0] <= ty_w;
    for (int k = 1; k < Rl; k++) begin
      ty_q[k] <= ty_q[k-1];
    end
    tz_q[0] <= tz_w;
    for (int k = 1; k < 2*Rl; k++) begin
      tz_q[k] <= tz_q[k-1];
    end
  end

  always_comb begin
    ty_neg_w.c = ty_q[Rl-1].c;
    ty_neg_w.s = -ty_q[Rl-1].s;
  end

  eulr_rot u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tx_vld_w),
    .a_i     (vy_q[Lat-1]),
    .b_i     (vz_q[Lat-1]),
    .pass_i  (vx_q[Lat-1]),
    .trig_i  (tx_w),
    .valid_o (r1_vld_w),
    .p_o     (r1_y_w),
    .r_o     (r1_z_w),
    .pass_o  (r1_x_w)
  );

  eulr_rot u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r1_vld_w),
    .a_i     (r1_x_w),
    .b_i     (r1_z_w),
    .pass_i  (r1_y_w),
    .trig_i  (ty_neg_w),
    .valid_o (r2_vld_w),
    .p_o     (r2_x_w),
    .r_o     (r2_z_w),
    .pass_o  (r2_y_w)
  );

  eulr_rot u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r2_vld_w),
    .a_i     (r2_x_w),
    .b_i     (r2_y_w),
    .pass_i  (r2_z_w),
    .trig_i  (tz_q[2*Rl-1]),
    .valid_o (r3_vld_w),
    .p_o     (r3_x_w),
    .r_o     (r3_y_w),
    .pass_o  (r3_z_w)
  );

  always_ff @(posedge clk_i) begin
    ox_q <= sat(r3_x_w);
    oy_q <= sat(r3_y_w);
    oz_q <= sat(r3_z_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= r3_vld_w;
    end
  end

  assign valid_o     = ovld_q;
  assign rotated_x_o = ox_q;
  assign rotated_y_o = oy_q;
  assign rotated_z_o = oz_q;

endmodule
